FILE: rtl/ltfd_pkg.sv
// Shared types and constants for the length/type frame deframer.
// No dependencies; every other file imports this package.
`default_nettype none

package ltfd_pkg;

    localparam int LEN_W     = 26;   // payload length and max-length register width
    localparam int HDR_W     = 32;   // big-endian length field on the wire
    localparam int HDR_LEN_B = 4;    // length bytes before the type byte

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(50 * 1024 * 1024);

    typedef enum logic [1:0] {
        RK_PAYLOAD = 2'd0,
        RK_EMPTY   = 2'd1,
        RK_ERROR   = 2'd2
    } t_result_kind;

    typedef struct packed {
        t_result_kind      result_kind;
        logic [7:0]        frame_type;
        logic [7:0]        payload_byte;
        logic [LEN_W-1:0]  frame_length;
        logic              last_of_frame;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/ltfd_if.sv
// Channel interfaces of the deframer: byte input, result output, config write.
// Depends on ltfd_pkg for the length width.
`default_nettype none

interface ltfd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, kind, data_byte, input ready);
    modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface ltfd_out_if;
    import ltfd_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       result_kind;
    logic [7:0]       frame_type;
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] frame_length;
    logic             last_of_frame;

    modport source (output valid, result_kind, frame_type, payload_byte, frame_length,
                    last_of_frame, input ready);
    modport sink   (input valid, result_kind, frame_type, payload_byte, frame_length,
                    last_of_frame, output ready);
endinterface

interface ltfd_cfg_if;
    import ltfd_pkg::*;
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/ltfd_parser.sv
// Header/payload parse state and per-byte result generation.
// Depends on ltfd_pkg.
`default_nettype none

module ltfd_parser
    import ltfd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic             i_kind,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic [LEN_W-1:0] i_max_len,
    output logic                  o_res_valid,
    output t_result               o_res
);

    logic             r_in_payload, n_in_payload;
    logic [2:0]       r_hdr_cnt,    n_hdr_cnt;
    logic [HDR_W-1:0] r_shift,      n_shift;
    logic [7:0]       r_type,       n_type;
    logic [LEN_W-1:0] r_left,       n_left;

    logic             len_high;
    logic             len_bad;
    logic             last_byte;

    assign len_high  = (r_shift[HDR_W-1:LEN_W] != '0);
    assign len_bad   = len_high || (r_shift[LEN_W-1:0] > i_max_len);
    assign last_byte = (r_left <= LEN_W'(1));

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_shift      = r_shift;
        n_type       = r_type;
        n_left       = r_left;
        o_res_valid  = 1'b0;
        o_res.result_kind   = RK_PAYLOAD;
        o_res.frame_type    = r_type;
        o_res.payload_byte  = '0;
        o_res.frame_length  = r_shift[LEN_W-1:0];
        o_res.last_of_frame = 1'b0;

        if (i_take) begin
            if (i_kind) begin
                // link dropped: forget the whole parse
                n_in_payload = 1'b0;
                n_hdr_cnt    = '0;
                n_shift      = '0;
                n_type       = '0;
                n_left       = '0;
            end else if (r_in_payload) begin
                o_res_valid         = 1'b1;
                o_res.payload_byte  = i_data_byte;
                o_res.last_of_frame = last_byte;
                if (last_byte) begin
                    n_in_payload = 1'b0;
                    n_left       = '0;
                end else begin
                    n_left = r_left - LEN_W'(1);
                end
            end else if (r_hdr_cnt < 3'(HDR_LEN_B)) begin
                n_shift   = {r_shift[HDR_W-9:0], i_data_byte};
                n_hdr_cnt = r_hdr_cnt + 3'd1;
            end else begin
                // type byte: check the length, then report an error or an empty frame, or start the payload
                n_type           = i_data_byte;
                n_hdr_cnt        = '0;
                o_res.frame_type = i_data_byte;
                if (len_bad) begin
                    o_res_valid        = 1'b1;
                    o_res.result_kind  = RK_ERROR;
                    o_res.frame_length = len_high ? '1 : r_shift[LEN_W-1:0];
                    n_shift            = '0;
                end else if (r_shift == '0) begin
                    o_res_valid         = 1'b1;
                    o_res.result_kind   = RK_EMPTY;
                    o_res.last_of_frame = 1'b1;
                end else begin
                    n_in_payload = 1'b1;
                    n_left       = r_shift[LEN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
            r_shift      <= '0;
            r_type       <= '0;
            r_left       <= '0;
        end else begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_shift      <= n_shift;
            r_type       <= n_type;
            r_left       <= n_left;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ltfd_out_buf.sv
// Two-entry result buffer (output register plus skid) with registered ready.
// Depends on ltfd_pkg.
`default_nettype none

module ltfd_out_buf
    import ltfd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_out_ready,
    output t_result      o_res
);

    logic    r_main_v, n_main_v;
    logic    r_skid_v, n_skid_v;
    t_result r_main,   n_main;
    t_result r_skid,   n_skid;
    logic    pop;

    assign pop     = r_main_v && i_out_ready;
    assign o_ready = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_res   = r_main;

    always_comb begin
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        n_main   = r_main;
        n_skid   = r_skid;
        if (r_skid_v) begin
            // no push possible while skid is occupied
            if (pop) begin
                n_main   = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_v || pop) begin
                n_main   = i_res;
                n_main_v = 1'b1;
            end else begin
                n_skid   = i_res;
                n_skid_v = 1'b1;
            end
        end else if (pop) begin
            n_main_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

FILE: rtl/length_type_frame_deframer_top.sv
// Top level of the length/type frame deframer.
// Depends on ltfd_pkg, ltfd_if, ltfd_parser and ltfd_out_buf.
//
// Usage:
//   i_in_ch  : byte requests. kind 0 carries a received byte, kind 1 means the
//              link dropped and clears the parse (no result).
//   o_out_ch : result requests. A payload byte per frame byte, one empty-frame
//              result for a zero length, or one bad-length error, both at the type
//              byte. Other header bytes give no result.
//   i_cfg_ch : writes max_payload_len (26 bits). Always ready; write it only
//              while the block is idle.
// Throughput: one byte request per cycle, sustained, as long as results drain.
// Each result is registered in the output buffer before it appears on o_out_ch.
// The parse state is advanced in the same cycle the byte is accepted; the
// result register plus one skid entry decouple the two sides, so ready on the
// input is a flop and drops only after the receiver stalls with a result held.
// Reset (i_rst_n low, synchronous): parse returns to header collection, the
// result buffer empties and max_payload_len returns to 50 MiB.
`default_nettype none

module length_type_frame_deframer_top
    import ltfd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ltfd_in_if.sink    i_in_ch,
    ltfd_out_if.source o_out_ch,
    ltfd_cfg_if.sink   i_cfg_ch
);

    logic [LEN_W-1:0] r_max_len;
    logic             in_take;
    logic             in_ready;
    logic             res_valid;
    t_result          res;
    t_result          out_res;

    // config register: always take the write
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_ch.valid) begin
            r_max_len <= i_cfg_ch.data;
        end
    end

    assign i_in_ch.ready = in_ready;
    assign in_take       = i_in_ch.valid && in_ready;

    ltfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (in_take),
        .i_kind      (i_in_ch.kind),
        .i_data_byte (i_in_ch.data_byte),
        .i_max_len   (r_max_len),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // hold results here while the receiver stalls
    ltfd_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_res       (res),
        .o_ready     (in_ready),
        .o_valid     (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .o_res       (out_res)
    );

    assign o_out_ch.result_kind   = out_res.result_kind;
    assign o_out_ch.frame_type    = out_res.frame_type;
    assign o_out_ch.payload_byte  = out_res.payload_byte;
    assign o_out_ch.frame_length  = out_res.frame_length;
    assign o_out_ch.last_of_frame = out_res.last_of_frame;

endmodule

`default_nettype wire

FILE: rtl/ltfd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
// Depends on ltfd_pkg.
`default_nettype none

module ltfd_checker
    import ltfd_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic [1:0]       i_result_kind,
    input wire logic [7:0]       i_payload_byte,
    input wire logic             i_last_of_frame
);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result_kind == RK_EMPTY |-> i_last_of_frame)
        else $error("empty frame not marked last");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_result_kind == RK_ERROR |-> !i_last_of_frame && i_payload_byte == 8'd0)
        else $error("error result carries data or last mark");

    // input backpressure only follows an output stall
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_out_valid && !i_out_ready))
        else $error("input ready dropped without output stall");

endmodule

bind length_type_frame_deframer_top ltfd_checker u_ltfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in_ch.ready),
    .i_out_valid     (o_out_ch.valid),
    .i_out_ready     (o_out_ch.ready),
    .i_result_kind   (o_out_ch.result_kind),
    .i_payload_byte  (o_out_ch.payload_byte),
    .i_last_of_frame (o_out_ch.last_of_frame)
);

`default_nettype wire
